>>> rtl/core/chst_pkg.sv
`default_nettype none

package chst_pkg;

    localparam int CAP_W   = 9;
    localparam int KEY_W   = 32;
    localparam int ID_W    = 8;
    // Bucket count is at most (3 * 511) / 2 = 766, so it fits in 10 bits.
    localparam int NB_W    = 10;
    localparam int DIGIT_W = 4;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_DUPLICATE = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_HEAD_RD,
        ST_HEAD_LD,
        ST_WALK,
        ST_WALK_CMP,
        ST_INS_CELL,
        ST_INS_LINK,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_HIT,
        RES_NOT_FOUND,
        RES_DUPLICATE,
        RES_FULL,
        RES_INSERT
    } res_sel_t;

    typedef struct packed {
        logic     clr_step;
        logic     accept;
        logic     div_step;
        logic     head_ld;
        logic     walk_adv;
        logic     ins_cell;
        logic     ins_link;
        logic     load_out;
        res_sel_t res_sel;
    } ctl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic walk_end;
        logic key_match;
        logic is_find;
        logic table_full;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/chained_hash_symbol_table.sv
// Steps: an accepted request first takes the key's remainder by the bucket count, one
//   4-bit digit at a time over ceil(KEY_BITS / 4) digits (8 for 32-bit keys), then
//   reads the bucket head and walks the chain cell by cell; a miss ends with one more
//   walk check, and an insert then writes the new cell and links it into the chain.
// Requests: one at a time; the next is taken once the result is in the output register.
// Reset: all (3 * CELLS) / 2 bucket heads (384 by default) are swept to empty
//   with in_stall high; a capacity write empties the table and repeats the sweep.
`default_nettype none

module chained_hash_symbol_table
    import chst_pkg::*;
#(
    parameter int CELLS    = 256,
    parameter int KEY_BITS = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             cmd,
    input  wire logic [KEY_W-1:0] key,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic      [ID_W-1:0]  id,
    output logic      [1:0]       status,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata
);

    ctl_cmd_t ctl;
    dp_stat_t stat;

    chst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cfg_we   (cfg_we),
        .stat     (stat),
        .ctl      (ctl),
        .in_stall (in_stall)
    );

    chst_datapath #(
        .CELLS    (CELLS),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .key       (key),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .stat      (stat),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .id        (id),
        .status    (status)
    );

endmodule

`default_nettype wire

>>> rtl/core/chst_ram.sv
`default_nettype none

module chst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/chst_ctrl.sv
`default_nettype none

module chst_ctrl
    import chst_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     cfg_we,
    input  wire dp_stat_t stat,
    output ctl_cmd_t      ctl,
    output logic          in_stall
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        // A capacity write empties the table, so the bucket heads are swept again.
        priority if (cfg_we)
        begin
            state_next = ST_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (stat.clr_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_next = ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (stat.div_last)
                    begin
                        state_next = ST_HEAD_RD;
                    end
                end
                ST_HEAD_RD:
                begin
                    state_next = ST_HEAD_LD;
                end
                ST_HEAD_LD:
                begin
                    state_next = ST_WALK;
                end
                ST_WALK:
                begin
                    if (!stat.walk_end)
                    begin
                        state_next = ST_WALK_CMP;
                    end
                    else if (stat.is_find || stat.table_full)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_INS_CELL;
                    end
                end
                ST_WALK_CMP:
                begin
                    state_next = stat.key_match ? ST_DONE : ST_WALK;
                end
                ST_INS_CELL:
                begin
                    state_next = ST_INS_LINK;
                end
                ST_INS_LINK:
                begin
                    state_next = ST_DONE;
                end
                ST_DONE:
                begin
                    if (stat.out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_CLEAR;
                end
            endcase
        end
    end

    always_comb
    begin
        ctl         = '0;
        ctl.res_sel = RES_NONE;
        in_stall    = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
            end
            ST_IDLE:
            begin
                ctl.accept = in_valid;
            end
            ST_DIV:
            begin
                ctl.div_step = 1'b1;
            end
            ST_HEAD_RD:
            begin
                ctl.res_sel = RES_NONE;
            end
            ST_HEAD_LD:
            begin
                ctl.head_ld = 1'b1;
            end
            ST_WALK:
            begin
                if (stat.walk_end)
                begin
                    if (stat.is_find)
                    begin
                        ctl.res_sel = RES_NOT_FOUND;
                    end
                    else if (stat.table_full)
                    begin
                        ctl.res_sel = RES_FULL;
                    end
                end
            end
            ST_WALK_CMP:
            begin
                if (stat.key_match)
                begin
                    ctl.res_sel = stat.is_find ? RES_HIT : RES_DUPLICATE;
                end
                else
                begin
                    ctl.walk_adv = 1'b1;
                end
            end
            ST_INS_CELL:
            begin
                ctl.ins_cell = 1'b1;
            end
            ST_INS_LINK:
            begin
                ctl.ins_link = 1'b1;
                ctl.res_sel  = RES_INSERT;
            end
            ST_DONE:
            begin
                ctl.load_out = stat.out_free;
            end
            default:
            begin
                ctl.res_sel = RES_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/chst_datapath.sv
`default_nettype none

module chst_datapath
    import chst_pkg::*;
#(
    parameter int CELLS    = 256,
    parameter int KEY_BITS = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd,
    input  wire logic [KEY_W-1:0] key,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata,
    input  wire ctl_cmd_t         ctl,
    output dp_stat_t              stat,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output logic      [ID_W-1:0]  id,
    output logic      [1:0]       status
);

    localparam int CW      = $clog2(CELLS + 1);
    localparam int CIW     = $clog2(CELLS);
    localparam int BUCKETS = (3 * CELLS) / 2;
    localparam int BAW     = $clog2(BUCKETS);
    localparam int SKB     = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int DIGITS  = (SKB + DIGIT_W - 1) / DIGIT_W;
    localparam int PADB    = DIGITS * DIGIT_W;
    localparam int DCW     = $clog2(DIGITS + 1);
    localparam int EW      = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [CW-1:0] NIL = CW'(CELLS);

    // Control registers.
    logic [CAP_W-1:0] cap_reg,       cap_next;
    logic [CW-1:0]    used_reg,      used_next;
    logic [BAW-1:0]   clr_addr_reg,  clr_addr_next;
    logic [DCW-1:0]   digit_cnt_reg, digit_cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers.
    logic             find_reg,       find_next;
    logic [SKB-1:0]   key_reg,        key_next;
    logic [PADB-1:0]  shift_reg,      shift_next;
    logic [NB_W-1:0]  rem_reg,        rem_next;
    logic [NB_W-1:0]  nb_reg,         nb_next;
    logic [CW-1:0]    cur_reg,        cur_next;
    logic [CW-1:0]    tail_reg,       tail_next;
    logic [CW-1:0]    steps_reg,      steps_next;
    logic [ID_W-1:0]  res_id_reg,     res_id_next;
    status_t          res_status_reg, res_status_next;
    logic [ID_W-1:0]  id_reg,         id_next;
    status_t          status_reg,     status_next;

    logic [EW-1:0]       cap_ext;
    logic [EW-1:0]       eff_cap;
    logic [EW+1:0]       triple;
    logic [NB_W-1:0]     nb_cur;
    logic [NB_W-1:0]     rem_step;
    logic [BAW+NB_W-1:0] rem_wide;
    logic [BAW-1:0]      bucket;
    logic [CW+ID_W-1:0]  cur_wide;
    logic [CW+ID_W-1:0]  used_wide;
    logic                tail_nil;
    logic                clr_last;

    logic            head_we;
    logic [BAW-1:0]  head_waddr;
    logic [CW-1:0]   head_wdata;
    logic [CW-1:0]   head_rdata;
    logic [SKB-1:0]  key_rdata;
    logic            next_we;
    logic [CIW-1:0]  next_waddr;
    logic [CW-1:0]   next_wdata;
    logic [CW-1:0]   next_rdata;

    // Capacity is saturated to 1..CELLS; the bucket count is floor(3 * cap / 2).
    assign cap_ext = EW'(cap_reg);
    always_comb
    begin
        priority if (cap_reg == '0)
        begin
            eff_cap = EW'(1);
        end
        else if (cap_ext > EW'(CELLS))
        begin
            eff_cap = EW'(CELLS);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign triple = {1'b0, eff_cap, 1'b0} + {2'b00, eff_cap};
    assign nb_cur = triple[NB_W:1];

    // Restoring remainder, one key digit per cycle, most significant first.
    always_comb
    begin
        logic [NB_W:0]   t;
        logic [NB_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < DIGIT_W; i++)
        begin
            t = {r, shift_reg[PADB-1-i]};
            if (t >= {1'b0, nb_reg})
            begin
                t = t - {1'b0, nb_reg};
            end
            r = t[NB_W-1:0];
        end
        rem_step = r;
    end

    assign rem_wide  = {{BAW{1'b0}}, rem_reg};
    assign bucket    = rem_wide[BAW-1:0];
    assign cur_wide  = {{ID_W{1'b0}}, cur_reg};
    assign used_wide = {{ID_W{1'b0}}, used_reg};
    assign tail_nil  = (tail_reg >= NIL);
    assign clr_last  = (clr_addr_reg == BAW'(BUCKETS - 1));

    assign stat.clr_last   = clr_last;
    assign stat.div_last   = (digit_cnt_reg == DCW'(1));
    assign stat.walk_end   = (cur_reg >= NIL) || (steps_reg >= NIL);
    assign stat.key_match  = (key_rdata == key_reg);
    assign stat.is_find    = find_reg;
    assign stat.table_full = (EW'(used_reg) >= eff_cap);
    assign stat.out_free   = !out_valid_reg || !out_stall;

    // Bucket heads: swept to empty after reset or a capacity write, then
    // written when a new cell starts an empty chain.
    assign head_we    = ctl.clr_step || (ctl.ins_link && tail_nil);
    assign head_waddr = ctl.clr_step ? clr_addr_reg : bucket;
    assign head_wdata = ctl.clr_step ? NIL : used_reg;

    // Chain links: a new cell ends its chain, then the old tail points at it.
    assign next_we    = ctl.ins_cell || (ctl.ins_link && !tail_nil);
    assign next_waddr = ctl.ins_cell ? used_reg[CIW-1:0] : tail_reg[CIW-1:0];
    assign next_wdata = ctl.ins_cell ? NIL : used_reg;

    chst_ram #(
        .WIDTH (CW),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (bucket),
        .rdata (head_rdata)
    );

    chst_ram #(
        .WIDTH (SKB),
        .DEPTH (CELLS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ctl.ins_cell),
        .waddr (used_reg[CIW-1:0]),
        .wdata (key_reg),
        .raddr (cur_reg[CIW-1:0]),
        .rdata (key_rdata)
    );

    chst_ram #(
        .WIDTH (CW),
        .DEPTH (CELLS)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (cur_reg[CIW-1:0]),
        .rdata (next_rdata)
    );

    always_comb
    begin
        cap_next       = cap_reg;
        used_next      = used_reg;
        clr_addr_next  = clr_addr_reg;
        digit_cnt_next = digit_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cfg_we)
        begin
            cap_next      = cfg_wdata;
            used_next     = '0;
            clr_addr_next = '0;
        end
        else
        begin
            if (ctl.clr_step)
            begin
                clr_addr_next = clr_last ? '0 : clr_addr_reg + BAW'(1);
            end
            if (ctl.ins_link)
            begin
                used_next = used_reg + CW'(1);
            end
        end

        if (ctl.accept)
        begin
            digit_cnt_next = DCW'(DIGITS);
        end
        else if (ctl.div_step)
        begin
            digit_cnt_next = digit_cnt_reg - DCW'(1);
        end

        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        find_next       = find_reg;
        key_next        = key_reg;
        shift_next      = shift_reg;
        rem_next        = rem_reg;
        nb_next         = nb_reg;
        cur_next        = cur_reg;
        tail_next       = tail_reg;
        steps_next      = steps_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        id_next         = id_reg;
        status_next     = status_reg;

        if (ctl.accept)
        begin
            find_next  = cmd;
            key_next   = key[SKB-1:0];
            shift_next = PADB'(key[SKB-1:0]);
            rem_next   = '0;
            nb_next    = nb_cur;
        end
        else if (ctl.div_step)
        begin
            rem_next   = rem_step;
            shift_next = shift_reg << DIGIT_W;
        end

        if (ctl.head_ld)
        begin
            cur_next   = head_rdata;
            tail_next  = NIL;
            steps_next = '0;
        end
        else if (ctl.walk_adv)
        begin
            cur_next   = next_rdata;
            tail_next  = cur_reg;
            steps_next = steps_reg + CW'(1);
        end

        unique case (ctl.res_sel)
            RES_NONE:
            begin
                res_id_next = res_id_reg;
            end
            RES_HIT:
            begin
                res_id_next     = cur_wide[ID_W-1:0];
                res_status_next = STATUS_OK;
            end
            RES_NOT_FOUND:
            begin
                res_id_next     = '0;
                res_status_next = STATUS_NOT_FOUND;
            end
            RES_DUPLICATE:
            begin
                res_id_next     = '0;
                res_status_next = STATUS_DUPLICATE;
            end
            RES_FULL:
            begin
                res_id_next     = '0;
                res_status_next = STATUS_FULL;
            end
            RES_INSERT:
            begin
                res_id_next     = used_wide[ID_W-1:0];
                res_status_next = STATUS_OK;
            end
            default:
            begin
                res_id_next = res_id_reg;
            end
        endcase

        if (ctl.load_out)
        begin
            id_next     = res_id_reg;
            status_next = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_W'(256);
            used_reg      <= '0;
            clr_addr_reg  <= '0;
            digit_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            used_reg      <= used_next;
            clr_addr_reg  <= clr_addr_next;
            digit_cnt_reg <= digit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        find_reg       <= find_next;
        key_reg        <= key_next;
        shift_reg      <= shift_next;
        rem_reg        <= rem_next;
        nb_reg         <= nb_next;
        cur_reg        <= cur_next;
        tail_reg       <= tail_next;
        steps_reg      <= steps_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        id_reg         <= id_next;
        status_reg     <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign id        = id_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

>>> rtl/core/chst_checker.sv
`default_nettype none

module chst_checker
    import chst_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_stall,
    input wire logic            out_valid,
    input wire logic            out_stall,
    input wire logic [ID_W-1:0] id,
    input wire logic [1:0]      status,
    input wire logic            cfg_we
);

    // A result waiting on a stalled output keeps its fields.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(id) && $stable(status)))
        else $error("stalled result changed or dropped");

    // Every error result carries a zero id.
    a_err_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_OK)) |-> (id == '0))
        else $error("error result with nonzero id");

    // One request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while another is in progress");

    // A capacity write starts the bucket sweep, which holds off requests.
    a_cfg_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> in_stall)
        else $error("request port open right after a capacity write");

endmodule

bind chained_hash_symbol_table chst_checker u_chst_checker (.*);

`default_nettype wire

>>> tb/tb_chained_hash_symbol_table.sv
`timescale 1ns / 1ps

module tb_chained_hash_symbol_table
    import chst_pkg::*;
();

    localparam int          TB_CELLS    = 256;
    localparam int          TB_BUCKETS  = (3 * TB_CELLS) / 2;
    localparam logic [8:0]  EMPTY_LINK  = 9'(TB_CELLS);
    localparam int unsigned CYCLE_LIMIT = 5000000;
    localparam int          ITEM_TARGET = 1300;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    typedef enum int {
        ACT_REQUEST,
        ACT_SET_CAPACITY,
        ACT_WAIT_IDLE
    } act_kind_t;

    typedef struct {
        act_kind_t          kind;
        logic               op;
        logic [KEY_W-1:0]   key;
        logic [CAP_W-1:0]   cap;
    } plan_step_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        status_t         status;
    } table_answer_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic               cmd       = OP_INSERT;
    logic [KEY_W-1:0]   key       = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [ID_W-1:0]    id;
    logic [1:0]         status;
    logic               cfg_we    = 1'b0;
    logic [CAP_W-1:0]   cfg_wdata = '0;

    plan_step_t         plan_q[$];
    logic [KEY_W-1:0]   plan_keys[$];
    int                 plan_items;
    table_answer_t      answer_q[$];
    int                 mismatch_count;
    int                 results_seen;

    // Shadow copy of the table contents.
    logic [CAP_W-1:0]   shadow_cap;
    logic [8:0]         shadow_head [0:TB_BUCKETS-1];
    logic [KEY_W-1:0]   shadow_key  [0:TB_CELLS-1];
    logic [8:0]         shadow_next [0:TB_CELLS-1];
    int unsigned        shadow_used;

    chained_hash_symbol_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .id        (id),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned usable_cells();
        if (shadow_cap == 0)
            return 1;
        if (shadow_cap > TB_CELLS)
            return TB_CELLS;
        return shadow_cap;
    endfunction

    function automatic void empty_table(logic [CAP_W-1:0] cap);
        shadow_cap = cap;
        for (int b = 0; b < TB_BUCKETS; b++)
            shadow_head[b] = EMPTY_LINK;
        shadow_used = 0;
    endfunction

    function automatic table_answer_t lookup_or_insert(logic op, logic [KEY_W-1:0] k);
        table_answer_t ans;
        int unsigned   spread;
        int unsigned   bkt;
        int unsigned   cur;
        int unsigned   tail;
        int unsigned   hit;
        int unsigned   steps;
        spread = (3 * usable_cells()) / 2;
        if (spread == 0)
            spread = 1;
        bkt   = k % spread;
        cur   = shadow_head[bkt];
        tail  = TB_CELLS;
        hit   = TB_CELLS;
        steps = 0;
        while (steps < TB_CELLS && cur < TB_CELLS && hit == TB_CELLS)
        begin
            tail = cur;
            if (shadow_key[cur] == k)
                hit = cur;
            else
                cur = shadow_next[cur];
            steps++;
        end
        ans.id = '0;
        if (op == OP_FIND)
        begin
            if (hit < TB_CELLS)
            begin
                ans.id     = ID_W'(hit);
                ans.status = STATUS_OK;
            end
            else
                ans.status = STATUS_NOT_FOUND;
        end
        else if (hit < TB_CELLS)
            ans.status = STATUS_DUPLICATE;
        else if (shadow_used >= usable_cells())
            ans.status = STATUS_FULL;
        else
        begin
            shadow_key[shadow_used]  = k;
            shadow_next[shadow_used] = EMPTY_LINK;
            if (tail < TB_CELLS)
                shadow_next[tail] = 9'(shadow_used);
            else
                shadow_head[bkt] = 9'(shadow_used);
            ans.id      = ID_W'(shadow_used);
            ans.status  = STATUS_OK;
            shadow_used = shadow_used + 1;
        end
        return ans;
    endfunction

    // Mostly no wait, sometimes a short one, rarely a long one.
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key(int unsigned style, int unsigned spread,
                                                   int unsigned lane);
        case (style)
            0: return $urandom;
            1: return $urandom_range(0, 63);
            2: return spread * $urandom_range(0, 2000) + ((lane + $urandom_range(0, 1)) % spread);
            default: return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 63);
        endcase
    endfunction

    task automatic queue_request(logic op, logic [KEY_W-1:0] k);
        plan_step_t s;
        s.kind = ACT_REQUEST;
        s.op   = op;
        s.key  = k;
        s.cap  = '0;
        plan_q.push_back(s);
        if (op == OP_INSERT)
            plan_keys.push_back(k);
        plan_items++;
    endtask

    task automatic queue_capacity(logic [CAP_W-1:0] v);
        plan_step_t s;
        s.kind = ACT_SET_CAPACITY;
        s.op   = OP_INSERT;
        s.key  = '0;
        s.cap  = v;
        plan_q.push_back(s);
        plan_keys.delete();
    endtask

    task automatic queue_pause();
        plan_step_t s;
        s.kind = ACT_WAIT_IDLE;
        s.op   = OP_INSERT;
        s.key  = '0;
        s.cap  = '0;
        plan_q.push_back(s);
    endtask

    initial
    begin : plan_proc
        logic [CAP_W-1:0] cap_pick;
        int unsigned      usable;
        int unsigned      spread;
        int unsigned      style;
        int unsigned      lane;
        int unsigned      phase_len;
        int unsigned      r;
        plan_items = 0;
        empty_table(9'd256);

        // Empty table, extreme keys, a two-deep chain, duplicates and a walk that misses.
        queue_request(OP_FIND, 32'd0);
        queue_request(OP_INSERT, 32'd0);
        queue_request(OP_INSERT, 32'hFFFF_FFFF);
        queue_request(OP_INSERT, 32'd384);
        queue_request(OP_FIND, 32'd384);
        queue_request(OP_FIND, 32'd0);
        queue_request(OP_FIND, 32'hFFFF_FFFF);
        queue_request(OP_INSERT, 32'd0);
        queue_request(OP_FIND, 32'd768);

        // One cell: full table, and the duplicate check ahead of the full check.
        queue_capacity(9'd1);
        queue_request(OP_INSERT, 32'd5);
        queue_request(OP_INSERT, 32'd7);
        queue_request(OP_INSERT, 32'd5);
        queue_request(OP_FIND, 32'd7);
        queue_request(OP_FIND, 32'd5);

        // Out-of-range capacities saturate at both ends.
        queue_capacity(9'd0);
        queue_request(OP_INSERT, 32'hA5A5_A5A5);
        queue_request(OP_INSERT, 32'd1);
        queue_capacity(9'd511);
        queue_request(OP_INSERT, 32'h8000_0000);
        queue_request(OP_FIND, 32'h8000_0000);

        queue_capacity(9'd2);
        queue_request(OP_INSERT, 32'd3);
        queue_request(OP_INSERT, 32'd6);
        queue_request(OP_INSERT, 32'd9);
        queue_request(OP_FIND, 32'd6);
        queue_pause();

        // Fill the full table so every id value shows up, then overflow it.
        queue_capacity(9'd256);
        repeat (258)
            queue_request(OP_INSERT, $urandom);
        queue_request(OP_FIND, plan_keys[0]);
        queue_request(OP_FIND, plan_keys[255]);
        queue_request(OP_FIND, plan_keys[256]);
        repeat (4)
            queue_request(OP_FIND, plan_keys[$urandom_range(0, 255)]);

        while (plan_items < ITEM_TARGET)
        begin
            r = $urandom_range(0, 9);
            case (r)
                0:       cap_pick = 9'd256;
                1:       cap_pick = 9'd1;
                2:       cap_pick = 9'd511;
                3:       cap_pick = $urandom_range(257, 511);
                4, 5:    cap_pick = $urandom_range(2, 8);
                default: cap_pick = $urandom_range(1, 255);
            endcase
            queue_capacity(cap_pick);
            usable    = (cap_pick == 0) ? 1 : ((cap_pick > TB_CELLS) ? TB_CELLS : cap_pick);
            spread    = (3 * usable) / 2;
            if (spread == 0)
                spread = 1;
            style     = $urandom_range(0, 3);
            lane      = $urandom_range(0, spread - 1);
            phase_len = $urandom_range(10, 100);
            for (int n = 0; n < phase_len; n++)
            begin
                if (n == phase_len / 2 && $urandom_range(0, 3) == 0)
                    queue_pause();
                r = $urandom_range(0, 99);
                if (plan_keys.size() == 0 || r < 35)
                    queue_request(OP_INSERT, fresh_key(style, spread, lane));
                else if (r < 45)
                    queue_request(OP_INSERT, plan_keys[$urandom_range(0, plan_keys.size() - 1)]);
                else if (r < 80)
                    queue_request(OP_FIND, plan_keys[$urandom_range(0, plan_keys.size() - 1)]);
                else
                    queue_request(OP_FIND, fresh_key(style, spread, lane));
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        logic        nx_valid;
        logic        nx_we;
        plan_step_t  s;
        int unsigned send_gap;
        int unsigned send_calm;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cmd       <= OP_INSERT;
            key       <= '0;
            cfg_we    <= 1'b0;
            cfg_wdata <= '0;
            send_gap  = 0;
            send_calm = 0;
        end
        else
        begin
            nx_valid = in_valid;
            nx_we    = 1'b0;
            if (in_valid && !in_stall)
            begin
                answer_q.push_back(lookup_or_insert(cmd, key));
                nx_valid = 1'b0;
            end
            if (!nx_valid && plan_q.size() > 0)
            begin
                if (send_gap > 0)
                    send_gap = send_gap - 1;
                else
                begin
                    case (plan_q[0].kind)
                        ACT_REQUEST:
                        begin
                            s        = plan_q.pop_front();
                            nx_valid = 1'b1;
                            cmd      <= s.op;
                            key      <= s.key;
                            if (send_calm > 0)
                            begin
                                send_calm = send_calm - 1;
                                send_gap  = 0;
                            end
                            else if ($urandom_range(0, 39) == 0)
                            begin
                                send_calm = $urandom_range(20, 80);
                                send_gap  = 0;
                            end
                            else
                                send_gap = pick_idle();
                        end
                        ACT_SET_CAPACITY:
                        begin
                            // Only touch the register once the block has gone quiet.
                            if (answer_q.size() == 0 && !out_valid && !in_stall && !cfg_we)
                            begin
                                s         = plan_q.pop_front();
                                nx_we     = 1'b1;
                                cfg_wdata <= s.cap;
                                empty_table(s.cap);
                            end
                        end
                        default:
                        begin
                            if (answer_q.size() == 0 && !out_valid)
                                s = plan_q.pop_front();
                        end
                    endcase
                end
            end
            in_valid <= nx_valid;
            cfg_we   <= nx_we;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_proc
        logic          nx_stall;
        table_answer_t want;
        int unsigned   stall_left;
        int unsigned   calm_left;
        int unsigned   hold_left;
        if (!rst_n)
        begin
            out_stall      <= 1'b0;
            stall_left     = 0;
            calm_left      = 0;
            hold_left      = 0;
            results_seen   = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (answer_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 100)
                        $display("%0t: result with nothing pending: id %0d status %0d",
                                 $time, id, status);
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (id !== want.id)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 100)
                            $display("%0t: id expected %0d got %0d", $time, want.id, id);
                    end
                    if (status !== want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 100)
                            $display("%0t: status expected %0d got %0d",
                                     $time, want.status, status);
                    end
                end
                // A long hold-off now and then, so requests back up behind the result.
                if (results_seen % 500 == 250)
                    hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                nx_stall  = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                nx_stall   = 1'b1;
            end
            else if (calm_left > 0)
            begin
                calm_left = calm_left - 1;
                nx_stall  = 1'b0;
            end
            else
            begin
                nx_stall = 1'b0;
                if ($urandom_range(0, 59) == 0)
                    calm_left = $urandom_range(30, 150);
                else if ($urandom_range(0, 2) == 0)
                    stall_left = pick_idle();
            end
            out_stall <= nx_stall;
        end
    end

    initial
    begin : watchdog_proc
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("chained_hash_symbol_table: mismatch");
        $finish;
    end

    initial
    begin : run_proc
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Sample between edges so the driver's updates for this cycle have settled.
        @(negedge clk);
        while (plan_q.size() != 0 || in_valid || answer_q.size() != 0)
            @(negedge clk);
        // Give a stray extra result time to show up.
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && answer_q.size() == 0)
            $display("chained_hash_symbol_table: match");
        else
            $display("chained_hash_symbol_table: mismatch");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/chst_pkg.sv
rtl/core/chst_ram.sv
rtl/core/chst_ctrl.sv
rtl/core/chst_datapath.sv
rtl/core/chained_hash_symbol_table.sv
rtl/core/chst_checker.sv
tb/tb_chained_hash_symbol_table.sv
